// ===== rtl/core/wldc_pkg.sv =====
`timescale 1ns / 1ps
package wldc_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int COUNT_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_THR  = 2'd1;

  localparam logic [SAMPLE_W-1:0] EMPTY_THR_RST = 12'd900;
  localparam logic [SAMPLE_W-1:0] FULL_THR_RST  = 12'd3500;

  typedef enum logic [1:0] {
    EVT_NONE    = 2'd0,
    EVT_EMPTIED = 2'd1,
    EVT_FULL    = 2'd2
  } evt_code_t;

  typedef struct packed {
    logic                is_load;
    logic [COUNT_W-1:0]  count_value;
    logic                full;
    logic [SAMPLE_W-1:0] mean;
  } item_t;

  typedef struct packed {
    logic            empty;
    logic            full;
    logic [QC_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic                mean_valid;
    logic [SAMPLE_W-1:0] mean_level;
    logic                armed;
    logic [COUNT_W-1:0]  event_count;
    evt_code_t           event_code;
    logic                even_cue;
  } result_t;

endpackage

// ===== rtl/core/wldc_front.sv =====
`timescale 1ns / 1ps
module wldc_front #(
  parameter int WINDOW_LEN = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_req_type,
  input  logic [wldc_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [wldc_pkg::COUNT_W-1:0]   in_counter_value,
  input  wldc_pkg::q_stat_t              q_stat,
  output logic                           q_push,
  output wldc_pkg::item_t                q_item
);

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = wldc_pkg::SAMPLE_W + $clog2(WINDOW_LEN);
  localparam int MUL_S  = SUM_W + $clog2(WINDOW_LEN);
  localparam int PROD_W = 2 * SUM_W + 1;
  localparam longint unsigned MUL_M = ((64'd1 << MUL_S) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam logic [SUM_W:0] MUL_K = (SUM_W + 1)'(MUL_M);

  logic [wldc_pkg::SAMPLE_W-1:0] win_mem [WINDOW_LEN];
  logic [wldc_pkg::SAMPLE_W-1:0] old_r;
  logic [SLOT_W-1:0]             slot_r;
  logic [SLOT_W-1:0]             slot_nxt;
  logic [SLOT_W-1:0]             rd_addr;
  logic [FILL_W-1:0]             fill_r;
  logic [SUM_W-1:0]              sum_r;
  logic [SUM_W-1:0]              sum_nxt;
  logic                          stg_v_r;
  logic                          stg_load_r;
  logic [wldc_pkg::COUNT_W-1:0]  stg_cnt_r;
  logic                          accept;
  logic                          smp;
  logic                          win_full;
  logic [wldc_pkg::QC_W:0]       occ;
  logic [PROD_W-1:0]             prod;

  assign accept   = in_push && !in_full;
  assign smp      = accept && !in_req_type;
  assign win_full = (fill_r == FILL_W'(WINDOW_LEN));
  assign slot_nxt = (slot_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_r + 1'b1;
  assign rd_addr  = smp ? slot_nxt : slot_r;
  assign sum_nxt  = sum_r + SUM_W'(in_sample) - (win_full ? SUM_W'(old_r) : '0);

  assign occ     = (wldc_pkg::QC_W + 1)'(q_stat.count) + (wldc_pkg::QC_W + 1)'(stg_v_r);
  assign in_full = (occ >= (wldc_pkg::QC_W + 1)'(wldc_pkg::QUEUE_DEPTH));

  // prefetch the slot that the next sample overwrites
  always_ff @(posedge clk) begin
    if (smp) begin
      win_mem[slot_r] <= in_sample;
    end
    old_r <= win_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      fill_r  <= '0;
      sum_r   <= '0;
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= accept;
      if (smp) begin
        slot_r <= slot_nxt;
        sum_r  <= sum_nxt;
        if (!win_full) begin
          fill_r <= fill_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_load_r <= in_req_type;
      stg_cnt_r  <= in_counter_value;
    end
  end

  assign prod = PROD_W'(sum_r) * PROD_W'(MUL_K);

  assign q_push             = stg_v_r;
  assign q_item.is_load     = stg_load_r;
  assign q_item.count_value = stg_cnt_r;
  assign q_item.full        = win_full;
  assign q_item.mean        = prod[MUL_S +: wldc_pkg::SAMPLE_W];

endmodule

// ===== rtl/core/wldc_fifo.sv =====
`timescale 1ns / 1ps
module wldc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wldc_pkg::item_t   push_item,
  input  logic              pop,
  output wldc_pkg::item_t   pop_item,
  output wldc_pkg::q_stat_t stat
);

  wldc_pkg::item_t             entry_r [wldc_pkg::QUEUE_DEPTH];
  logic [wldc_pkg::QA_W-1:0]   wr_ptr_r;
  logic [wldc_pkg::QA_W-1:0]   rd_ptr_r;
  logic [wldc_pkg::QC_W-1:0]   cnt_r;
  logic                        do_push;
  logic                        do_pop;

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == wldc_pkg::QC_W'(wldc_pkg::QUEUE_DEPTH));
  assign stat.count = cnt_r;
  assign pop_item   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/wldc_back.sv =====
`timescale 1ns / 1ps
module wldc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [wldc_pkg::SAMPLE_W-1:0] empty_thr,
  input  logic [wldc_pkg::SAMPLE_W-1:0] full_thr,
  input  wldc_pkg::item_t               q_item,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic                          out_pop,
  output logic                          out_empty,
  output wldc_pkg::result_t             res
);

  logic                         armed_r;
  logic                         armed_nxt;
  logic [wldc_pkg::COUNT_W-1:0] events_r;
  logic [wldc_pkg::COUNT_W-1:0] events_nxt;
  logic                         res_v_r;
  wldc_pkg::result_t            res_r;
  wldc_pkg::result_t            res_nxt;
  wldc_pkg::evt_code_t          code;
  logic                         cue;
  logic                         take;

  assign take = !q_empty && (!res_v_r || out_pop);

  always_comb begin
    armed_nxt  = armed_r;
    events_nxt = events_r;
    code       = wldc_pkg::EVT_NONE;
    cue        = 1'b0;
    if (q_item.is_load) begin
      events_nxt = q_item.count_value;
    end else if (q_item.full) begin
      if (!armed_r && (q_item.mean < empty_thr)) begin
        cue       = !events_r[0];
        armed_nxt = 1'b1;
        code      = wldc_pkg::EVT_EMPTIED;
      end else if (armed_r && (q_item.mean >= full_thr)) begin
        if (events_r != '1) begin
          events_nxt = events_r + 1'b1;
        end
        armed_nxt = 1'b0;
        code      = wldc_pkg::EVT_FULL;
      end
    end
  end

  always_comb begin
    res_nxt.mean_valid  = q_item.full;
    res_nxt.mean_level  = q_item.full ? q_item.mean : '0;
    res_nxt.armed       = armed_nxt;
    res_nxt.event_count = events_nxt;
    res_nxt.event_code  = code;
    res_nxt.even_cue    = cue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b0;
      events_r <= '0;
      res_v_r  <= 1'b0;
    end else begin
      if (take) begin
        armed_r  <= armed_nxt;
        events_r <= events_nxt;
        res_v_r  <= 1'b1;
      end else if (out_pop) begin
        res_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign q_pop     = take;
  assign out_empty = !res_v_r;
  assign res       = res_r;

endmodule

// ===== rtl/core/windowed_level_detector_counter.sv =====
`timescale 1ns / 1ps
// Sliding-window level detector with hysteresis and a saturating event counter. It takes one
// word per clock and returns one word per clock while the result side pops; a word passes the
// staging register, the queue and the result register. The window store is a single-port-write
// memory whose read port prefetches the slot the next sample overwrites, so the running sum
// updates on each sample; the mean is the sum times a fixed reciprocal, one multiply a
// cycle. A four-word queue sits between the window and detector stages; full rises once queue
// and staged word fill it. Threshold writes are accepted at once; write them only while idle.
module windowed_level_detector_counter #(
  parameter int WINDOW_LEN = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_req_type,
  input  logic [wldc_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [wldc_pkg::COUNT_W-1:0]   in_counter_value,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic                           out_mean_valid,
  output logic [wldc_pkg::SAMPLE_W-1:0]  out_mean_level,
  output logic                           out_armed,
  output logic [wldc_pkg::COUNT_W-1:0]   out_event_count,
  output logic [1:0]                     out_event_code,
  output logic                           out_even_cue,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wldc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wldc_pkg::SAMPLE_W-1:0]  cfg_data
);

  logic [wldc_pkg::SAMPLE_W-1:0] empty_thr_r;
  logic [wldc_pkg::SAMPLE_W-1:0] full_thr_r;
  wldc_pkg::q_stat_t             q_stat;
  wldc_pkg::item_t               q_in;
  wldc_pkg::item_t               q_out;
  logic                          q_push;
  logic                          q_pop;
  wldc_pkg::result_t             res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_thr_r <= wldc_pkg::EMPTY_THR_RST;
      full_thr_r  <= wldc_pkg::FULL_THR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        wldc_pkg::CFG_EMPTY_THR: empty_thr_r <= cfg_data;
        wldc_pkg::CFG_FULL_THR:  full_thr_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  wldc_front #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_req_type      (in_req_type),
    .in_sample        (in_sample),
    .in_counter_value (in_counter_value),
    .q_stat           (q_stat),
    .q_push           (q_push),
    .q_item           (q_in)
  );

  wldc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .pop_item  (q_out),
    .stat      (q_stat)
  );

  wldc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty_thr (empty_thr_r),
    .full_thr  (full_thr_r),
    .q_item    (q_out),
    .q_empty   (q_stat.empty),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .res       (res)
  );

  assign out_mean_valid  = res.mean_valid;
  assign out_mean_level  = res.mean_level;
  assign out_armed       = res.armed;
  assign out_event_count = res.event_count;
  assign out_event_code  = res.event_code;
  assign out_even_cue    = res.even_cue;

  a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("window stage pushed into a full queue");

  a_emptied_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_event_code == wldc_pkg::EVT_EMPTIED)) |-> out_armed)
    else $error("emptied word without armed detector");

  a_full_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_event_code == wldc_pkg::EVT_FULL)) |-> !out_armed)
    else $error("full word with armed detector");

  a_cue_on_emptied: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_even_cue) |-> (out_event_code == wldc_pkg::EVT_EMPTIED))
    else $error("even cue outside an emptied word");

  a_no_mean_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_mean_valid) |->
      ((out_mean_level == '0) && (out_event_code == wldc_pkg::EVT_NONE)))
    else $error("event or level reported before the window filled");

endmodule
